// ----- src/qed_pkg.sv -----
// Shared types, constants and lookup functions for the quadrature encoder decoder.
// No dependencies; imported by every other file of the block.
package qed_pkg;

   localparam int DATA_W     = 32;
   localparam int RATE_W     = 8;
   localparam int TYPE_W     = 3;
   localparam int TICKS_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int SQR_W      = 2 * RATE_W;
   localparam int CUBE_W     = 3 * RATE_W;
   localparam int PROD_W     = DATA_W + CUBE_W;
   localparam int DIV_STEPS  = DATA_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int SHIFT_W    = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODER_TYPE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALUE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SPAN_TICKS = 3'd6;

   // encoder types
   localparam logic [TYPE_W-1:0] ENC_DETENT_3    = 3'd0;
   localparam logic [TYPE_W-1:0] ENC_DETENT_0    = 3'd1;
   localparam logic [TYPE_W-1:0] ENC_DETENT_0_3  = 3'd2;
   localparam logic [TYPE_W-1:0] ENC_DETENT_1_2  = 3'd3;
   localparam logic [TYPE_W-1:0] ENC_DETENT_ALL  = 3'd4;

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ACCEL,
      ST_WRITE
   } dec_state_type;

   typedef enum logic [2:0] {
      AC_IDLE,
      AC_SQR,
      AC_CUBE,
      AC_DIV1,
      AC_MUL,
      AC_START2,
      AC_DIV2,
      AC_DONE
   } acc_state_type;

   typedef struct packed {
      logic [RATE_W-1:0]  min_rate;
      logic [RATE_W-1:0]  max_rate;
      logic [DATA_W-1:0]  min_value;
      logic [DATA_W-1:0]  max_value;
      logic [TICKS_W-1:0] full_span_ticks;
   } accel_cfg_type;

   typedef struct packed {
      logic              start;
      logic [CUBE_W-1:0] rem_init;
      logic [DATA_W-1:0] dividend;
      logic [CUBE_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   // index is {old state, new state}
   function automatic dir_type quad_dir(input logic [3:0] idx);
      dir_type d;
      case (idx)
         4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
         4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
         default:                  d = DIR_NONE;
      endcase
      return d;
   endfunction

   function automatic logic [3:0] detent_mask(input logic [TYPE_W-1:0] t);
      logic [3:0] m;
      case (t)
         ENC_DETENT_0:   m = 4'h1;
         ENC_DETENT_0_3: m = 4'h9;
         ENC_DETENT_1_2: m = 4'h6;
         ENC_DETENT_ALL: m = 4'hF;
         default:        m = 4'h8;
      endcase
      return m;
   endfunction

   function automatic logic [SHIFT_W-1:0] res_shift(input logic [TYPE_W-1:0] t);
      logic [SHIFT_W-1:0] s;
      case (t)
         ENC_DETENT_0_3: s = 2'd1;
         ENC_DETENT_1_2: s = 2'd1;
         ENC_DETENT_ALL: s = 2'd0;
         default:        s = 2'd2;
      endcase
      return s;
   endfunction

endpackage

// ----- src/qed_req_if.sv -----
// Sample channel: valid/ready handshake with one encoder sample as payload.
// Depends on qed_pkg.
interface qed_req_if
   import qed_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              pin_a;
   logic              pin_b;
   logic [DATA_W-1:0] now_ms;
   logic [RATE_W-1:0] rate_tps;

   modport source (output valid, output pin_a, output pin_b, output now_ms,
                   output rate_tps, input ready);
   modport sink   (input valid, input pin_a, input pin_b, input now_ms,
                   input rate_tps, output ready);
endinterface

// ----- src/qed_rsp_if.sv -----
// Result channel: valid/ready handshake carrying positions and detent flag.
// Depends on qed_pkg.
interface qed_rsp_if
   import qed_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] fine_position;
   logic signed [DATA_W-1:0] reported_position;
   logic                     detent_hit;

   modport source (output valid, output fine_position, output reported_position,
                   output detent_hit, input ready);
   modport sink   (input valid, input fine_position, input reported_position,
                   input detent_hit, output ready);
endinterface

// ----- src/qed_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on qed_pkg. Remainder seed must be below the divisor.
module qed_divider
   import qed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CUBE_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [CUBE_W-1:0]    den_ff, den_in;

   logic [CUBE_W:0]      shifted;
   logic [CUBE_W:0]      trial;
   logic                 take;
   logic                 last;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign take    = shifted >= {1'b0, den_ff};
   assign last    = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = cmd.rem_init;
         quo_in  = cmd.dividend;
         den_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = take ? trial[CUBE_W-1:0] : shifted[CUBE_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- src/qed_accel.sv -----
// Acceleration step sequencer: 1 + delta*s^3/span^3 using the shared divider.
// Depends on qed_pkg and qed_divider.
module qed_accel
   import qed_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RATE_W-1:0] rate,
   input  accel_cfg_type     cfg,
   output logic              done,
   output logic [DATA_W-1:0] step
);

   acc_state_type state_ff, state_in;

   logic [RATE_W-1:0] s_ff, s_in;
   logic [RATE_W-1:0] span_ff, span_in;
   logic [DATA_W-1:0] diff_ff, diff_in;
   logic              diff_pos_ff, diff_pos_in;
   logic [SQR_W-1:0]  s2_ff, s2_in;
   logic [SQR_W-1:0]  span2_ff, span2_in;
   logic [CUBE_W-1:0] s3_ff, s3_in;
   logic [CUBE_W-1:0] den_ff, den_in;
   logic [DATA_W-1:0] d_ff, d_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] step_ff, step_in;

   logic [RATE_W-1:0] rate_clamped;
   logic [DATA_W:0]   diff_wide;
   logic              no_span;
   logic [TICKS_W-1:0] ticks;
   div_cmd_type       div_cmd;
   div_rsp_type       div_rsp;

   qed_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign no_span   = cfg.max_rate <= cfg.min_rate;
   assign diff_wide = {cfg.max_value[DATA_W-1], cfg.max_value}
                    - {cfg.min_value[DATA_W-1], cfg.min_value};
   assign ticks     = (cfg.full_span_ticks == '0) ? TICKS_W'(1) : cfg.full_span_ticks;

   always_comb begin
      if (rate < cfg.min_rate) begin
         rate_clamped = cfg.min_rate;
      end else if (rate > cfg.max_rate) begin
         rate_clamped = cfg.max_rate;
      end else begin
         rate_clamped = rate;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         AC_IDLE: begin
            if (start) begin
               state_in = no_span ? AC_DONE : AC_SQR;
            end
         end
         AC_SQR:    state_in = AC_CUBE;
         AC_CUBE:   state_in = AC_DIV1;
         AC_DIV1: begin
            if (div_rsp.done) begin
               state_in = AC_MUL;
            end
         end
         AC_MUL:    state_in = AC_START2;
         AC_START2: state_in = AC_DIV2;
         AC_DIV2: begin
            if (div_rsp.done) begin
               state_in = AC_DONE;
            end
         end
         AC_DONE:   state_in = AC_IDLE;
         default:   state_in = AC_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      s_in        = s_ff;
      span_in     = span_ff;
      diff_in     = diff_ff;
      diff_pos_in = diff_pos_ff;
      s2_in       = s2_ff;
      span2_in    = span2_ff;
      s3_in       = s3_ff;
      den_in      = den_ff;
      d_in        = d_ff;
      prod_in     = prod_ff;
      step_in     = step_ff;
      div_cmd     = '0;
      done        = 1'b0;
      case (state_ff)
         AC_IDLE: begin
            if (start) begin
               s_in        = rate_clamped - cfg.min_rate;
               span_in     = cfg.max_rate - cfg.min_rate;
               diff_in     = diff_wide[DATA_W-1:0];
               diff_pos_in = !diff_wide[DATA_W] && (diff_wide[DATA_W-1:0] != '0);
               step_in     = DATA_W'(1);
            end
         end
         AC_SQR: begin
            s2_in            = SQR_W'(s_ff) * SQR_W'(s_ff);
            span2_in         = SQR_W'(span_ff) * SQR_W'(span_ff);
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = '0;
            div_cmd.dividend = diff_ff;
            div_cmd.divisor  = CUBE_W'(ticks);
         end
         AC_CUBE: begin
            s3_in  = CUBE_W'(s2_ff) * CUBE_W'(s_ff);
            den_in = CUBE_W'(span2_ff) * CUBE_W'(span_ff);
         end
         AC_DIV1: begin
            // delta truncates toward zero and is raised to at least one
            if (diff_pos_ff && (div_rsp.quotient != '0)) begin
               d_in = div_rsp.quotient;
            end else begin
               d_in = DATA_W'(1);
            end
         end
         AC_MUL: begin
            prod_in = PROD_W'(d_ff) * PROD_W'(s3_ff);
         end
         AC_START2: begin
            // s <= span, so the quotient fits 32 bits and the top part is below den
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = prod_ff[PROD_W-1:DATA_W];
            div_cmd.dividend = prod_ff[DATA_W-1:0];
            div_cmd.divisor  = den_ff;
         end
         AC_DIV2: begin
            if (div_rsp.done) begin
               step_in = div_rsp.quotient + DATA_W'(1);
            end
         end
         AC_DONE: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      s_ff        <= s_in;
      span_ff     <= span_in;
      diff_ff     <= diff_in;
      diff_pos_ff <= diff_pos_in;
      s2_ff       <= s2_in;
      span2_ff    <= span2_in;
      s3_ff       <= s3_in;
      den_ff      <= den_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
   end

   assign step = step_ff;

endmodule

// ----- src/quadrature_encoder_accel_decoder.sv -----
// Top level of the quadrature encoder decoder with debounce and acceleration.
// Depends on qed_pkg, qed_req_if, qed_rsp_if and qed_accel.
//
// Use:
//  - req_chan carries one sample per transfer: the two inverted encoder lines,
//    the wrapping millisecond time and the measured detent rate.
//  - rsp_chan returns exactly one result per sample: fine position, reported
//    position and the detent flag.
//  - csr_we/csr_index/csr_wdata write the seven settings; write only while idle.
// Flow:
//  - One sample is in flight at a time. Without an accepted move with nonzero
//    direction the sample passes from EVAL straight to WRITE. Such a move runs
//    the acceleration sequencer (two 32-step bit-serial divisions on one shared
//    divider plus the square, cube and multiply stages), which goes straight to
//    its done state when max_rate is not above min_rate.
// Reset: positions, line state and last-change time clear; settings take their
//    default values; no result is pending.
// Stall: the result sits in an output register; the next sample is taken
//    meanwhile and waits in its final stage until the register frees up.
module quadrature_encoder_accel_decoder
   import qed_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   qed_req_if.sink              req_chan,
   qed_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   dec_state_type state_ff, state_in;

   // settings
   logic [TYPE_W-1:0]  enc_type_ff;
   logic [RATE_W-1:0]  debounce_ff;
   accel_cfg_type      cfg_ff;

   // captured sample
   logic [1:0]         smp_pins_ff, smp_pins_in;
   logic [DATA_W-1:0]  smp_now_ff, smp_now_in;
   logic [RATE_W-1:0]  smp_rate_ff, smp_rate_in;

   // decoder state
   logic [1:0]         pin_state_ff, pin_state_in;
   logic [DATA_W-1:0]  fine_ff, fine_in;
   logic [DATA_W-1:0]  rep_ff, rep_in;
   logic [DATA_W-1:0]  last_ff, last_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  out_fine_ff, out_fine_in;
   logic [DATA_W-1:0]  out_rep_ff, out_rep_in;
   logic               out_hit_ff, out_hit_in;

   logic [DATA_W-1:0]  elapsed;
   logic               settled;
   logic               changed;
   logic               take;
   dir_type            dir;
   logic               need_step;
   logic [TYPE_W-1:0]  eff_type;
   logic [3:0]         det_mask;
   logic               hit;
   logic [DATA_W-1:0]  fine_next;
   logic               rsp_free;
   logic               commit;
   logic               accel_start;
   logic               accel_done;
   logic [DATA_W-1:0]  accel_step;

   qed_accel u_accel (
      .clock (clock),
      .reset (reset),
      .start (accel_start),
      .rate  (smp_rate_ff),
      .cfg   (cfg_ff),
      .done  (accel_done),
      .step  (accel_step)
   );

   // decision logic, valid from EVAL on; state does not move until commit
   assign elapsed   = smp_now_ff - last_ff;
   assign settled   = elapsed >= DATA_W'(debounce_ff);
   assign changed   = smp_pins_ff != pin_state_ff;
   assign take      = changed && settled;
   assign dir       = quad_dir({pin_state_ff, smp_pins_ff});
   assign need_step = take && (dir != DIR_NONE);
   // types beyond the table behave as the first one
   assign eff_type  = (enc_type_ff > ENC_DETENT_ALL) ? ENC_DETENT_3 : enc_type_ff;
   assign det_mask  = detent_mask(eff_type);
   assign hit       = take && det_mask[smp_pins_ff];
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      case (dir)
         DIR_UP:   fine_next = fine_ff + accel_step;
         DIR_DOWN: fine_next = fine_ff - accel_step;
         default:  fine_next = fine_ff;
      endcase
      if (!take) begin
         fine_next = fine_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL:  state_in = need_step ? ST_ACCEL : ST_WRITE;
         ST_ACCEL: begin
            if (accel_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = 1'b0;
      accel_start    = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_EVAL:  accel_start    = need_step;
         ST_WRITE: commit         = rsp_free;
         default:  commit         = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      smp_pins_in  = smp_pins_ff;
      smp_now_in   = smp_now_ff;
      smp_rate_in  = smp_rate_ff;
      pin_state_in = pin_state_ff;
      fine_in      = fine_ff;
      rep_in       = rep_ff;
      last_in      = last_ff;
      out_fine_in  = out_fine_ff;
      out_rep_in   = out_rep_ff;
      out_hit_in   = out_hit_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_chan.valid && req_chan.ready) begin
         smp_pins_in = {req_chan.pin_b, req_chan.pin_a};
         smp_now_in  = req_chan.now_ms;
         smp_rate_in = req_chan.rate_tps;
      end

      if (commit) begin
         if (take) begin
            pin_state_in = smp_pins_ff;
            fine_in      = fine_next;
         end
         if (hit) begin
            rep_in = DATA_W'($signed(fine_next) >>> res_shift(eff_type));
         end
         // any line change restarts the debounce window; a stable line
         // drags the last-change time along behind the present time
         if (changed) begin
            last_in = smp_now_ff;
         end else if (settled) begin
            last_in = smp_now_ff - DATA_W'(debounce_ff) - DATA_W'(1);
         end
         out_fine_in  = fine_next;
         out_rep_in   = hit ? DATA_W'($signed(fine_next) >>> res_shift(eff_type)) : rep_ff;
         out_hit_in   = hit;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         rsp_valid_ff          <= 1'b0;
         pin_state_ff          <= '0;
         fine_ff               <= '0;
         rep_ff                <= '0;
         last_ff               <= '0;
         enc_type_ff           <= ENC_DETENT_3;
         debounce_ff           <= RATE_W'(1);
         cfg_ff.min_rate       <= '0;
         cfg_ff.max_rate       <= RATE_W'(40);
         cfg_ff.min_value      <= '0;
         cfg_ff.max_value      <= DATA_W'(1000);
         cfg_ff.full_span_ticks <= TICKS_W'(100);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pin_state_ff <= pin_state_in;
         fine_ff      <= fine_in;
         rep_ff       <= rep_in;
         last_ff      <= last_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ENCODER_TYPE:    enc_type_ff            <= csr_wdata[TYPE_W-1:0];
               CSR_DEBOUNCE_MS:     debounce_ff            <= csr_wdata[RATE_W-1:0];
               CSR_MIN_RATE:        cfg_ff.min_rate        <= csr_wdata[RATE_W-1:0];
               CSR_MAX_RATE:        cfg_ff.max_rate        <= csr_wdata[RATE_W-1:0];
               CSR_MIN_VALUE:       cfg_ff.min_value       <= csr_wdata;
               CSR_MAX_VALUE:       cfg_ff.max_value       <= csr_wdata;
               CSR_FULL_SPAN_TICKS: cfg_ff.full_span_ticks <= csr_wdata[TICKS_W-1:0];
               default:             enc_type_ff            <= enc_type_ff;
            endcase
         end
      end
      smp_pins_ff <= smp_pins_in;
      smp_now_ff  <= smp_now_in;
      smp_rate_ff <= smp_rate_in;
      out_fine_ff <= out_fine_in;
      out_rep_ff  <= out_rep_in;
      out_hit_ff  <= out_hit_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.fine_position     = $signed(out_fine_ff);
   assign rsp_chan.reported_position = $signed(out_rep_ff);
   assign rsp_chan.detent_hit        = out_hit_ff;

endmodule
